[rtl/pauq5_pkg.sv]
// Package for the QARMA5 pointer authentication unit: payload types, operation
// and register codes, cipher constants and the round functions.
// Used by pauq5_cipher, pointer_auth_qarma5_unit and the testbench; depends on nothing.
`timescale 1ns / 1ps

package pauq5_pkg;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_AUTH    = 2'd1,
    OP_STRIP   = 2'd2,
    OP_GENERIC = 2'd3
  } pauq5_op_t;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    pauq5_op_t   op;
    logic [63:0] pointer;
    logic [63:0] modifier;
    logic [63:0] second_modifier;
    logic        use_second_modifier;
    logic        key_is_b;
  } pauq5_in_t;

  typedef struct packed {
    logic [63:0] result;
    logic        auth_failed;
  } pauq5_out_t;

  // Information that rides along the cipher pipeline next to the state.
  typedef struct packed {
    pauq5_op_t   op;
    logic [63:0] pointer;
    logic        key_is_b;
  } pauq5_side_t;

  localparam logic [63:0] QALPHA = 64'hc0ac29b7c97c50dd;

  localparam logic [63:0] RCON [5] = '{
    64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
    64'h082efa98ec4e6c89, 64'h452821e638d01377
  };

  localparam logic [3:0] PERM_FWD [16] = '{
    4'd13, 4'd6, 4'd11, 4'd0, 4'd7, 4'd12, 4'd1, 4'd10,
    4'd8, 4'd3, 4'd14, 4'd5, 4'd2, 4'd9, 4'd4, 4'd15
  };
  localparam logic [3:0] PERM_INV [16] = '{
    4'd3, 4'd6, 4'd12, 4'd9, 4'd14, 4'd11, 4'd1, 4'd4,
    4'd8, 4'd13, 4'd7, 4'd2, 4'd5, 4'd0, 4'd10, 4'd15
  };
  localparam logic [3:0] SBOX_FWD [16] = '{
    4'd11, 4'd6, 4'd8, 4'd15, 4'd12, 4'd0, 4'd9, 4'd14,
    4'd3, 4'd7, 4'd4, 4'd5, 4'd13, 4'd2, 4'd1, 4'd10
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'd5, 4'd14, 4'd13, 4'd8, 4'd10, 4'd11, 4'd1, 4'd9,
    4'd2, 4'd6, 4'd15, 4'd0, 4'd4, 4'd12, 4'd7, 4'd3
  };
  localparam logic [3:0] TW_FWD [16] = '{
    4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd2, 4'd3, 4'd8,
    4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd1, 4'd10, 4'd9
  };
  localparam logic [3:0] TW_INV [16] = '{
    4'd12, 4'd13, 4'd5, 4'd6, 4'd0, 4'd1, 4'd2, 4'd3,
    4'd7, 4'd15, 4'd14, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11
  };
  localparam logic [15:0] TW_FWD_ROT = 16'hd894;
  localparam logic [15:0] TW_INV_ROT = 16'h8f41;

  function automatic logic [3:0] rotl1(input logic [3:0] c);
    return {c[2:0], c[3]};
  endfunction

  function automatic logic [3:0] rotl2(input logic [3:0] c);
    return {c[1:0], c[3:2]};
  endfunction

  function automatic logic [63:0] shuffle_fwd(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 16; i++) begin
      o[i*4 +: 4] = v[{PERM_FWD[i], 2'b00} +: 4];
    end
    return o;
  endfunction

  function automatic logic [63:0] shuffle_inv(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 16; i++) begin
      o[i*4 +: 4] = v[{PERM_INV[i], 2'b00} +: 4];
    end
    return o;
  endfunction

  function automatic logic [63:0] sub_fwd(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 16; i++) begin
      o[i*4 +: 4] = SBOX_FWD[v[i*4 +: 4]];
    end
    return o;
  endfunction

  function automatic logic [63:0] sub_inv(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 16; i++) begin
      o[i*4 +: 4] = SBOX_INV[v[i*4 +: 4]];
    end
    return o;
  endfunction

  // Column mixing; the matrix is an involution, so one function serves both ways.
  function automatic logic [63:0] mix(input logic [63:0] v);
    logic [63:0] o;
    logic [3:0]  c0, c1, c2, c3;
    for (int i = 0; i < 4; i++) begin
      c0 = v[i*4 +: 4];
      c1 = v[(i+4)*4 +: 4];
      c2 = v[(i+8)*4 +: 4];
      c3 = v[(i+12)*4 +: 4];
      o[(i+12)*4 +: 4] = rotl1(c2) ^ rotl2(c1) ^ rotl1(c0);
      o[(i+8)*4 +: 4]  = rotl1(c3) ^ rotl1(c1) ^ rotl2(c0);
      o[(i+4)*4 +: 4]  = rotl2(c3) ^ rotl1(c2) ^ rotl1(c0);
      o[i*4 +: 4]      = rotl1(c3) ^ rotl2(c2) ^ rotl1(c1);
    end
    return o;
  endfunction

  // Tweak schedule: cell permutation plus an LFSR step on marked cells.
  function automatic logic [63:0] tweak_fwd(input logic [63:0] v);
    logic [63:0] o;
    logic [3:0]  c;
    for (int i = 0; i < 16; i++) begin
      c = v[{TW_FWD[i], 2'b00} +: 4];
      if (TW_FWD_ROT[i]) begin
        c = {c[0] ^ c[1], c[3:1]};
      end
      o[i*4 +: 4] = c;
    end
    return o;
  endfunction

  function automatic logic [63:0] tweak_inv(input logic [63:0] v);
    logic [63:0] o;
    logic [3:0]  c;
    for (int i = 0; i < 16; i++) begin
      c = v[{TW_INV[i], 2'b00} +: 4];
      if (TW_INV_ROT[i]) begin
        c = {c[2:0], c[0] ^ c[3]};
      end
      o[i*4 +: 4] = c;
    end
    return o;
  endfunction

  // Forward round; the first round skips the diffusion layer.
  function automatic logic [63:0] fwd_round(input logic [63:0] w, input logic [63:0] t,
                                            input logic [63:0] k1, input logic [63:0] rc,
                                            input logic first);
    logic [63:0] x;
    x = w ^ k1 ^ t ^ rc;
    if (!first) begin
      x = mix(shuffle_fwd(x));
    end
    return sub_fwd(x);
  endfunction

  // Backward round; t is the tweak after its inverse update.
  function automatic logic [63:0] bwd_round(input logic [63:0] w, input logic [63:0] t,
                                            input logic [63:0] k1, input logic [63:0] rc,
                                            input logic last);
    logic [63:0] x;
    x = sub_inv(w);
    if (!last) begin
      x = shuffle_inv(mix(x));
    end
    return x ^ rc ^ k1 ^ t ^ QALPHA;
  endfunction

  // Derived whitening key: rotate right by one, fold the top bit into bit 0.
  function automatic logic [63:0] derive_mk0(input logic [63:0] k0);
    return {k0[0], k0[63:1]} ^ {63'd0, k0[63]};
  endfunction

endpackage

[rtl/pointer_auth_qarma5_unit.sv]
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  pauq5_in_t: op, pointer, modifiers, flags
// out_      output     out_valid/out_stall pauq5_out_t: result, auth_failed
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data (key halves)
//
// One item is taken per cycle unless in_stall is high; each accepted item passes
// through six cipher stages and then the output register. The outer stages hold two
// rounds each, and the middle two each hold one round and half of the reflector.
// Reset (rst_n low, synchronous) empties the pipeline and clears both key halves.
// A stall on the output holds the whole pipeline, so in_stall follows out_stall
// while a result waits. Depends on pauq5_pkg and pauq5_cipher.
`timescale 1ns / 1ps

module pointer_auth_qarma5_unit
  import pauq5_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pauq5_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pauq5_out_t           out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0] key_low_r, key_high_r;
  logic        en;

  logic [63:0] ci_text, ci_tweak;
  pauq5_side_t ci_side;
  logic        co_valid;
  logic [63:0] co_text;
  pauq5_side_t co_side;

  logic        out_valid_r;
  pauq5_out_t  out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_KEY_HIGH: key_high_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // The pipeline advances unless a finished item sits unread at the output.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    ci_side.op       = in_data.op;
    ci_side.pointer  = in_data.pointer;
    ci_side.key_is_b = in_data.key_is_b;

    if (in_data.use_second_modifier && in_data.op != OP_GENERIC) begin
      ci_tweak = {in_data.second_modifier[36:5], in_data.modifier[35:4]};
    end else begin
      ci_tweak = in_data.modifier;
    end

    unique case (in_data.op)
      OP_ADD:     ci_text = {{16{in_data.pointer[63]}}, in_data.pointer[47:0]};
      OP_AUTH:    ci_text = {{16{in_data.pointer[55]}}, in_data.pointer[47:0]};
      OP_STRIP:   ci_text = in_data.pointer;
      OP_GENERIC: ci_text = in_data.pointer;
      default:    ci_text = in_data.pointer;
    endcase
  end

  pauq5_cipher u_cipher (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_text   (ci_text),
    .in_tweak  (ci_tweak),
    .in_side   (ci_side),
    .key_low   (key_low_r),
    .key_high  (key_high_r),
    .out_valid (co_valid),
    .out_text  (co_text),
    .out_side  (co_side)
  );

  always_comb begin
    logic [63:0] code, orig, ptr;
    logic        match;

    ptr   = co_side.pointer;
    code  = co_text;
    orig  = {{16{ptr[55]}}, ptr[47:0]};
    match = (code[63:56] == ptr[63:56]) && (code[54:48] == ptr[54:48]);
    out_data_nxt.auth_failed = 1'b0;

    unique case (co_side.op)
      OP_ADD: begin
        // A pointer with a non-canonical top gets a code that cannot match.
        if (ptr[63:48] != 16'h0000 && ptr[63:48] != 16'hffff) begin
          code[62] = ~code[62];
        end
        out_data_nxt.result = {code[63:56], ptr[63], code[54:48], ptr[47:0]};
      end
      OP_AUTH: begin
        out_data_nxt.result = orig;
        if (!match) begin
          out_data_nxt.result[62:61] = co_side.key_is_b ? 2'b10 : 2'b01;
          out_data_nxt.auth_failed   = 1'b1;
        end
      end
      OP_STRIP: begin
        out_data_nxt.result = orig;
      end
      OP_GENERIC: begin
        out_data_nxt.result = {code[63:32], 32'd0};
      end
      default: begin
        out_data_nxt.result = orig;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= co_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A failed authentication always leaves a poisoned, non-canonical top.
  a_fail_poison : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.auth_failed |->
      (out_data.result[62:61] == 2'b01 || out_data.result[62:61] == 2'b10))
    else $error("auth failure without poison bits");

  // Reset empties the whole pipeline, so no result shows right after it.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The cipher pipeline never moves while a result waits at the output.
  a_hold_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(co_text))
    else $error("pipeline advanced under output stall");

endmodule

[rtl/pauq5_cipher.sv]
// Six-stage pipelined QARMA5 encryption with 128-bit key and 64-bit tweak.
// Depends on pauq5_pkg for the round functions and the sideband type.
`timescale 1ns / 1ps

module pauq5_cipher
  import pauq5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_text,
  input  logic [63:0] in_tweak,
  input  pauq5_side_t in_side,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  output logic        out_valid,
  output logic [63:0] out_text,
  output pauq5_side_t out_side
);

  localparam int unsigned NSTG = 6;

  logic [NSTG-1:0] v_r;
  logic [63:0]     w_r    [NSTG];
  logic [63:0]     t_r    [NSTG];
  pauq5_side_t     side_r [NSTG];

  logic [63:0] w_nxt [NSTG];
  logic [63:0] t_nxt [NSTG];
  logic [63:0] mk0;

  assign mk0 = derive_mk0(key_high);

  always_comb begin
    logic [63:0] w, t;

    // Stage A: input whitening, forward rounds 0 and 1.
    w = in_text ^ key_high;
    t = in_tweak;
    w = fwd_round(w, t, key_low, RCON[0], 1'b1);
    t = tweak_fwd(t);
    w = fwd_round(w, t, key_low, RCON[1], 1'b0);
    t = tweak_fwd(t);
    w_nxt[0] = w;
    t_nxt[0] = t;

    // Stage B: forward rounds 2 and 3.
    w = fwd_round(w_r[0], t_r[0], key_low, RCON[2], 1'b0);
    t = tweak_fwd(t_r[0]);
    w = fwd_round(w, t, key_low, RCON[3], 1'b0);
    t = tweak_fwd(t);
    w_nxt[1] = w;
    t_nxt[1] = t;

    // Stage C: forward round 4 and the forward half of the reflector.
    w = fwd_round(w_r[1], t_r[1], key_low, RCON[4], 1'b0);
    t = tweak_fwd(t_r[1]);
    w = w ^ mk0 ^ t;
    w = mix(shuffle_fwd(w));
    w = sub_fwd(w);
    w = mix(shuffle_fwd(w));
    w = w ^ key_low;
    w_nxt[2] = w;
    t_nxt[2] = t;

    // Stage D: inverse half of the reflector, backward round 0.
    w = shuffle_inv(w_r[2]);
    w = sub_inv(w);
    w = shuffle_inv(mix(w));
    w = w ^ key_high ^ t_r[2];
    t = tweak_inv(t_r[2]);
    w = bwd_round(w, t, key_low, RCON[4], 1'b0);
    w_nxt[3] = w;
    t_nxt[3] = t;

    // Stage E: backward rounds 1 and 2.
    t = tweak_inv(t_r[3]);
    w = bwd_round(w_r[3], t, key_low, RCON[3], 1'b0);
    t = tweak_inv(t);
    w = bwd_round(w, t, key_low, RCON[2], 1'b0);
    w_nxt[4] = w;
    t_nxt[4] = t;

    // Stage F: backward rounds 3 and 4, output whitening.
    t = tweak_inv(t_r[4]);
    w = bwd_round(w_r[4], t, key_low, RCON[1], 1'b0);
    t = tweak_inv(t);
    w = bwd_round(w, t, key_low, RCON[0], 1'b1);
    w_nxt[5] = w ^ mk0;
    t_nxt[5] = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NSTG; s++) begin
        w_r[s] <= w_nxt[s];
        t_r[s] <= t_nxt[s];
      end
      side_r[0] <= in_side;
      for (int s = 1; s < NSTG; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_text  = w_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

endmodule

[dv/pauq5_tb_pkg.sv]
// Scoreboard for the QARMA5 pointer authentication unit testbench: an independent
// cipher and operation model plus the queue of results still to arrive.
// Depends on pauq5_pkg for the payload types, operation and register codes.
`timescale 1ns / 1ps

package pauq5_tb_pkg;
  import pauq5_pkg::*;

  localparam logic [63:0] ALPHA_C = 64'hc0ac29b7c97c50dd;
  localparam logic [63:0] ROUND_C [5] = '{
    64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
    64'h082efa98ec4e6c89, 64'h452821e638d01377
  };
  localparam int CELL_F [16] = '{13, 6, 11, 0, 7, 12, 1, 10, 8, 3, 14, 5, 2, 9, 4, 15};
  localparam int CELL_B [16] = '{3, 6, 12, 9, 14, 11, 1, 4, 8, 13, 7, 2, 5, 0, 10, 15};
  localparam logic [3:0] SB_F [16] = '{
    4'd11, 4'd6, 4'd8, 4'd15, 4'd12, 4'd0, 4'd9, 4'd14,
    4'd3, 4'd7, 4'd4, 4'd5, 4'd13, 4'd2, 4'd1, 4'd10
  };
  localparam logic [3:0] SB_B [16] = '{
    4'd5, 4'd14, 4'd13, 4'd8, 4'd10, 4'd11, 4'd1, 4'd9,
    4'd2, 4'd6, 4'd15, 4'd0, 4'd4, 4'd12, 4'd7, 4'd3
  };
  localparam int TWK_F [16] = '{4, 5, 6, 7, 11, 2, 3, 8, 12, 13, 14, 15, 0, 1, 10, 9};
  localparam int TWK_B [16] = '{12, 13, 5, 6, 0, 1, 2, 3, 7, 15, 14, 4, 8, 9, 10, 11};
  localparam logic [15:0] TWK_F_LFSR = 16'hd894;
  localparam logic [15:0] TWK_B_LFSR = 16'h8f41;

  class pac_scoreboard;
    logic [63:0] key_low;
    logic [63:0] key_high;
    pauq5_out_t  expected_q[$];
    int          n_errors;
    int          n_checked;
    int          n_auth_fail;
    int          op_seen [4];

    function new();
      key_low     = '0;
      key_high    = '0;
      n_errors    = 0;
      n_checked   = 0;
      n_auth_fail = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function logic [63:0] permute(logic [63:0] v, bit inverse);
      logic [63:0] o;
      int          j;
      o = '0;
      for (int i = 0; i < 16; i++) begin
        j = inverse ? CELL_B[i] : CELL_F[i];
        o[i*4 +: 4] = v[j*4 +: 4];
      end
      return o;
    endfunction

    function logic [63:0] sbox_layer(logic [63:0] v, bit inverse);
      logic [63:0] o;
      o = '0;
      for (int i = 0; i < 16; i++) begin
        o[i*4 +: 4] = inverse ? SB_B[v[i*4 +: 4]] : SB_F[v[i*4 +: 4]];
      end
      return o;
    endfunction

    function logic [3:0] rl(logic [3:0] c, int n);
      logic [7:0] d;
      d = {c, c} << n;
      return d[7:4];
    endfunction

    function logic [63:0] mix_columns(logic [63:0] v);
      logic [63:0] o;
      logic [3:0]  c0, c1, c2, c3;
      o = '0;
      for (int i = 0; i < 4; i++) begin
        c0 = v[i*4 +: 4];
        c1 = v[(i+4)*4 +: 4];
        c2 = v[(i+8)*4 +: 4];
        c3 = v[(i+12)*4 +: 4];
        o[(i+12)*4 +: 4] = rl(c2, 1) ^ rl(c1, 2) ^ rl(c0, 1);
        o[(i+8)*4 +: 4]  = rl(c3, 1) ^ rl(c1, 1) ^ rl(c0, 2);
        o[(i+4)*4 +: 4]  = rl(c3, 2) ^ rl(c2, 1) ^ rl(c0, 1);
        o[i*4 +: 4]      = rl(c3, 1) ^ rl(c2, 2) ^ rl(c1, 1);
      end
      return o;
    endfunction

    function logic [63:0] tweak_update(logic [63:0] t, bit inverse);
      logic [63:0] o;
      logic [3:0]  c;
      int          j;
      o = '0;
      for (int i = 0; i < 16; i++) begin
        j = inverse ? TWK_B[i] : TWK_F[i];
        c = t[j*4 +: 4];
        if (inverse && TWK_B_LFSR[i]) begin
          c = {c[2:0], c[0] ^ c[3]};
        end else if (!inverse && TWK_F_LFSR[i]) begin
          c = {c[0] ^ c[1], c[3:1]};
        end
        o[i*4 +: 4] = c;
      end
      return o;
    endfunction

    // key_high is the whitening half (k0), key_low the core half (k1).
    function logic [63:0] encrypt(logic [63:0] data, logic [63:0] tweak);
      logic [63:0] k0, k1, mk0, w, t;
      k0  = key_high;
      k1  = key_low;
      mk0 = (k0 << 63) | ((k0 >> 1) ^ (k0 >> 63));
      t   = tweak;
      w   = data ^ k0;
      for (int r = 0; r < 5; r++) begin
        w = w ^ k1 ^ t ^ ROUND_C[r];
        if (r > 0) begin
          w = mix_columns(permute(w, 1'b0));
        end
        w = sbox_layer(w, 1'b0);
        t = tweak_update(t, 1'b0);
      end
      w = w ^ mk0 ^ t;
      w = mix_columns(permute(w, 1'b0));
      w = sbox_layer(w, 1'b0);
      w = mix_columns(permute(w, 1'b0));
      w = w ^ k1;
      w = permute(w, 1'b1);
      w = sbox_layer(w, 1'b1);
      w = permute(mix_columns(w), 1'b1);
      w = w ^ k0 ^ t;
      for (int r = 0; r < 5; r++) begin
        w = sbox_layer(w, 1'b1);
        if (r < 4) begin
          w = permute(mix_columns(w), 1'b1);
        end
        t = tweak_update(t, 1'b1);
        w = w ^ ROUND_C[4-r] ^ k1 ^ t ^ ALPHA_C;
      end
      return w ^ mk0;
    endfunction

    function logic [63:0] extend_addr(logic [63:0] p, int sign_bit);
      return {{16{p[sign_bit]}}, p[47:0]};
    endfunction

    function pauq5_out_t pac_result(pauq5_in_t it);
      pauq5_out_t  r;
      logic [63:0] t, code, orig;
      r = '0;
      t = it.use_second_modifier ? {it.second_modifier[36:5], it.modifier[35:4]}
                                 : it.modifier;
      case (it.op)
        OP_ADD: begin
          code = encrypt(extend_addr(it.pointer, 63), t);
          // A non-canonical pointer gets a code that can never authenticate.
          if (it.pointer[63:48] != 16'h0000 && it.pointer[63:48] != 16'hffff) begin
            code[62] = ~code[62];
          end
          r.result = {code[63:56], it.pointer[63], code[54:48], it.pointer[47:0]};
        end
        OP_AUTH: begin
          orig     = extend_addr(it.pointer, 55);
          code     = encrypt(orig, t);
          r.result = orig;
          if ({code[63:56], code[54:48]} != {it.pointer[63:56], it.pointer[54:48]}) begin
            r.result[62:61] = it.key_is_b ? 2'b10 : 2'b01;
            r.auth_failed   = 1'b1;
          end
        end
        OP_STRIP: begin
          r.result = extend_addr(it.pointer, 55);
        end
        default: begin
          // The generic code always uses the first modifier alone.
          code     = encrypt(it.pointer, it.modifier);
          r.result = {code[63:32], 32'd0};
        end
      endcase
      return r;
    endfunction

    function void set_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
      if (idx == REG_KEY_LOW) begin
        key_low = v;
      end else if (idx == REG_KEY_HIGH) begin
        key_high = v;
      end
    endfunction

    function void note_item(pauq5_in_t it);
      expected_q.push_back(pac_result(it));
      op_seen[int'(it.op)]++;
    endfunction

    function void check_result(pauq5_out_t got);
      pauq5_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: result %h auth_failed %b", got.result, got.auth_failed);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (want.auth_failed) n_auth_fail++;
      if (got.result !== want.result) begin
        $error("result: expected %h, actual %h", want.result, got.result);
        n_errors++;
      end
      if (got.auth_failed !== want.auth_failed) begin
        $error("auth_failed: expected %b, actual %b", want.auth_failed, got.auth_failed);
        n_errors++;
      end
    endfunction
  endclass

endpackage

[dv/testbench.sv]
// Top-level testbench for pointer_auth_qarma5_unit: directed and random items,
// bursty input, patterned output stalls and key changes between phases.
// Depends on pauq5_pkg, pauq5_tb_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
  import pauq5_pkg::*;
  import pauq5_tb_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 160;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pauq5_in_t            in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pauq5_out_t           out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  pac_scoreboard sb;
  int            burst_left;
  int            n_key_sets;
  stall_mode_t   stall_mode = STALL_NONE;
  int            stall_left = 0;

  pointer_auth_qarma5_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // The receiver switches between randomly chosen stall patterns.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_addr();
    logic [63:0] r;
    r = rand64();
    case ($urandom_range(0, 5))
      0, 1:    return {16'h0000, r[47:0]};
      2, 3:    return {16'hffff, r[47:0]};
      4:       return r;
      default: return $urandom_range(0, 1) ? 64'h0 : '1;
    endcase
  endfunction

  function automatic logic [63:0] rand_modifier();
    case ($urandom_range(0, 7))
      0:       return 64'h0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic pauq5_in_t make_item(pauq5_op_t op, logic [63:0] ptr, logic [63:0] m1,
                                          logic [63:0] m2, logic usm, logic kb);
    pauq5_in_t it;
    it.op                  = op;
    it.pointer             = ptr;
    it.modifier            = m1;
    it.second_modifier     = m2;
    it.use_second_modifier = usm;
    it.key_is_b            = kb;
    return it;
  endfunction

  // Sender bursts: after a burst ends, valid drops for a random gap.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic send_item(input pauq5_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    pace();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_key(idx, v);
  endtask

  task automatic load_keys(input logic [63:0] lo, input logic [63:0] hi);
    drain();
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
    cfg_valid <= 1'b0;
    n_key_sets++;
  endtask

  task automatic run_directed();
    pauq5_in_t  signed_src [5];
    pauq5_in_t  it;
    pauq5_out_t s;
    signed_src[0] = make_item(OP_ADD, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0);
    signed_src[1] = make_item(OP_ADD, '1, '1, 64'h0, 1'b0, 1'b0);
    // Non-canonical upper bits: the code is spoiled on purpose.
    signed_src[2] = make_item(OP_ADD, 64'h1234_5678_9abc_def0, rand64(), rand64(), 1'b0, 1'b1);
    signed_src[3] = make_item(OP_ADD, 64'h8000_0000_0000_0000, '1, '1, 1'b1, 1'b0);
    signed_src[4] = make_item(OP_ADD, 64'h0000_7fff_ffff_ffff, rand64(), rand64(), 1'b1, 1'b1);
    foreach (signed_src[i]) send_item(signed_src[i]);
    foreach (signed_src[i]) begin
      s          = sb.pac_result(signed_src[i]);
      it         = signed_src[i];
      it.op      = OP_AUTH;
      it.pointer = s.result;
      send_item(it);
    end
    // Corrupted codes, poisoned with key A and then key B.
    s          = sb.pac_result(signed_src[0]);
    it         = signed_src[0];
    it.op      = OP_AUTH;
    it.pointer = s.result ^ (64'h1 << 48);
    send_item(it);
    s           = sb.pac_result(signed_src[1]);
    it          = signed_src[1];
    it.op       = OP_AUTH;
    it.pointer  = s.result ^ (64'h1 << 63);
    it.key_is_b = 1'b1;
    send_item(it);
    send_item(make_item(OP_AUTH, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0));
    send_item(make_item(OP_AUTH, '1, '1, '1, 1'b1, 1'b1));
    send_item(make_item(OP_STRIP, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0));
    send_item(make_item(OP_STRIP, '1, '1, '1, 1'b1, 1'b1));
    send_item(make_item(OP_STRIP, 64'h0080_0000_0000_0000, rand64(), rand64(), 1'b0, 1'b1));
    send_item(make_item(OP_STRIP, 64'hff7f_ffff_ffff_ffff, rand64(), rand64(), 1'b1, 1'b0));
    send_item(make_item(OP_GENERIC, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0));
    // The second modifier must have no effect on a generic code.
    send_item(make_item(OP_GENERIC, '1, '1, '1, 1'b1, 1'b1));
    send_item(make_item(OP_GENERIC, rand64(), rand64(), rand64(), 1'b1, 1'b0));
  endtask

  // Mostly sign-then-authenticate sequences, the rest unrelated random items.
  task automatic run_random(input int n);
    int         sent;
    int         pos;
    pauq5_in_t  a;
    pauq5_in_t  it;
    pauq5_out_t s;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 6) begin
        a = make_item(OP_ADD, rand_addr(), rand_modifier(), rand_modifier(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_item(a);
        s           = sb.pac_result(a);
        it          = a;
        it.op       = OP_AUTH;
        it.pointer  = s.result;
        it.key_is_b = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
          0: begin
            pos = $urandom_range(0, 14);
            it.pointer[pos < 8 ? 56 + pos : 40 + pos] = ~it.pointer[pos < 8 ? 56 + pos : 40 + pos];
          end
          1: it.modifier = it.modifier ^ (64'h1 << $urandom_range(0, 63));
          default: ;
        endcase
        send_item(it);
        sent += 2;
        if ($urandom_range(0, 2) == 0) begin
          it.op = OP_STRIP;
          send_item(it);
          sent++;
        end
      end else begin
        it = make_item(pauq5_op_t'($urandom_range(0, 3)), rand64(), rand64(), rand64(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    sb         = new();
    burst_left = $urandom_range(0, 40);
    n_key_sets = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed items run on the keys left by reset.
    run_directed();
    load_keys('1, '1);
    run_random(PHASE_ITEMS);
    load_keys(64'h0, '1);
    run_random(PHASE_ITEMS);
    load_keys('1, 64'h0);
    run_random(PHASE_ITEMS);
    load_keys(rand64(), rand64());
    run_random(PHASE_ITEMS);
    load_keys(rand64(), rand64());
    run_random(PHASE_ITEMS);
    drain();
    $display("Checked %0d results: %0d add, %0d authenticate, %0d strip, %0d generic items.",
             sb.n_checked, sb.op_seen[OP_ADD], sb.op_seen[OP_AUTH], sb.op_seen[OP_STRIP],
             sb.op_seen[OP_GENERIC]);
    $display("%0d authentication failures expected; reset keys plus %0d written key settings.",
             sb.n_auth_fail, n_key_sets);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS pointer_auth_qarma5_unit");
    end else begin
      $display("FAIL pointer_auth_qarma5_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL pointer_auth_qarma5_unit");
    $finish;
  end

endmodule
